// ----- sv/tmp_pkg.sv -----
`timescale 1ns / 1ps

package tmp_pkg;

	localparam int unsigned DATA_W    = 24;  // registers, position, velocity
	localparam int unsigned DT_W      = 16;  // elapsed time, Q0.16
	localparam int unsigned PROD_W    = 2 * DATA_W;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned SP_W      = 31;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [DATA_W-1:0] TARGET_RST = 24'd0;
	localparam logic [DATA_W-1:0] ACCEL_RST  = 24'd655360;
	localparam logic [DATA_W-1:0] SPEED_RST  = 24'd655360;
	localparam logic [DATA_W-1:0] CPF_RST    = 24'd309880;

	localparam logic [SP_W-1:0] SP_MAX = {SP_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CPF    = 8'd3;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// operand selection for the shared multiplier
	typedef enum logic [2:0] {
		MSEL_VV = 3'd0,  // velocity squared
		MSEL_AR = 3'd1,  // accel times remaining distance
		MSEL_DV = 3'd2,  // accel times elapsed
		MSEL_DP = 3'd3,  // velocity times elapsed
		MSEL_SP = 3'd4   // position times counts per foot
	} msel_t;

	typedef struct packed {
		logic  capture;   // input transfer, latch elapsed
		logic  start;     // clear position and velocity, arm move
		logic  stop;      // tick while armed but already at target
		logic  mul_en;
		msel_t msel;
		logic  save_vv;
		logic  save_brake;
		logic  upd_v;
		logic  upd_p;
		logic  load_out;
	} ctrl_t;

	typedef struct packed {
		logic moving;
		logic at_target;
		logic out_free;
	} sts_t;

endpackage

// ----- sv/tmp_ctrl.sv -----
`timescale 1ns / 1ps

module tmp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          s_cmd,
	input  tmp_pkg::sts_t sts,
	output tmp_pkg::ctrl_t ctrl
);
	import tmp_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_MUL_VV = 9'b000000010,
		ST_MUL_AR = 9'b000000100,
		ST_MUL_DV = 9'b000001000,
		ST_UPD_V  = 9'b000010000,
		ST_MUL_DP = 9'b000100000,
		ST_UPD_P  = 9'b001000000,
		ST_MUL_SP = 9'b010000000,
		ST_OUT    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d         = state_q;
		ctrl            = '0;
		ctrl.msel       = MSEL_SP;
		ctrl.capture    = accept;
		ctrl.start      = accept && (s_cmd == CMD_START);
		ctrl.stop       = accept && (s_cmd == CMD_TICK) && sts.moving && sts.at_target;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_cmd == CMD_TICK && sts.moving && !sts.at_target)
						state_d = ST_MUL_VV;
					else
						state_d = ST_MUL_SP;
				end
			end
			ST_MUL_VV: begin
				ctrl.mul_en = 1'b1;
				ctrl.msel   = MSEL_VV;
				state_d     = ST_MUL_AR;
			end
			ST_MUL_AR: begin
				ctrl.mul_en  = 1'b1;
				ctrl.msel    = MSEL_AR;
				ctrl.save_vv = 1'b1;
				state_d      = ST_MUL_DV;
			end
			ST_MUL_DV: begin
				ctrl.mul_en     = 1'b1;
				ctrl.msel       = MSEL_DV;
				ctrl.save_brake = 1'b1;
				state_d         = ST_UPD_V;
			end
			ST_UPD_V: begin
				ctrl.upd_v = 1'b1;
				state_d    = ST_MUL_DP;
			end
			ST_MUL_DP: begin
				ctrl.mul_en = 1'b1;
				ctrl.msel   = MSEL_DP;
				state_d     = ST_UPD_P;
			end
			ST_UPD_P: begin
				ctrl.upd_p = 1'b1;
				state_d    = ST_MUL_SP;
			end
			ST_MUL_SP: begin
				ctrl.mul_en = 1'b1;
				ctrl.msel   = MSEL_SP;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					ctrl.load_out = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted item did not start work");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> sts.out_free)
		else $error("result loaded over an untaken result");

	a_pos_then_sp: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.upd_p |=> ctrl.mul_en && ctrl.msel == MSEL_SP)
		else $error("setpoint multiply did not follow position update");

endmodule

// ----- sv/tmp_dpath.sv -----
`timescale 1ns / 1ps

module tmp_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tmp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tmp_pkg::DATA_W-1:0]       cfg_data,
	input  logic [tmp_pkg::DT_W-1:0]         s_elapsed,
	input  tmp_pkg::ctrl_t                   ctrl,
	output tmp_pkg::sts_t                    sts,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tmp_pkg::SP_W-1:0]         m_setpoint,
	output logic                             m_done
);
	import tmp_pkg::*;

	logic [DATA_W-1:0] tgt_q, accel_q, speed_q, cpf_q;
	logic [DATA_W-1:0] pos_q, vel_q;
	logic              moving_q;
	logic [DT_W-1:0]   dt_q;
	logic [PROD_W-1:0] prod_q, vv_q;
	logic              brake_q;
	logic              out_valid_q;
	logic [SP_W-1:0]   sp_q;
	logic              done_q;

	logic [DATA_W-1:0]   mul_a, mul_b, rem, dv, dp, vel_new, pos_new;
	logic [PROD_W-1:0]   prod_d;
	logic [PROD_W+1:0]   vv3, ar2;
	logic [DATA_W:0]     vsum, psum;
	logic [SP_W:0]       sp_raw;

	assign rem = tgt_q - pos_q;  // used only while position is below target
	assign dv  = prod_q[DATA_W+FRAC_W-1:FRAC_W];
	assign dp  = prod_q[DATA_W+FRAC_W-1:FRAC_W];

	always_comb begin
		unique case (ctrl.msel)
			MSEL_VV: begin mul_a = vel_q;   mul_b = vel_q; end
			MSEL_AR: begin mul_a = accel_q; mul_b = rem; end
			MSEL_DV: begin mul_a = accel_q; mul_b = {{(DATA_W-DT_W){1'b0}}, dt_q}; end
			MSEL_DP: begin mul_a = vel_q;   mul_b = {{(DATA_W-DT_W){1'b0}}, dt_q}; end
			MSEL_SP: begin mul_a = pos_q;   mul_b = cpf_q; end
			default: begin mul_a = '0;      mul_b = '0; end
		endcase
	end
	assign prod_d = mul_a * mul_b;

	// braking test 3*v*v > 2*a*rem
	assign vv3 = {2'b00, vv_q} + {1'b0, vv_q, 1'b0};
	assign ar2 = {1'b0, prod_q, 1'b0};

	assign vsum = {1'b0, vel_q} + {1'b0, dv};
	always_comb begin
		if (brake_q)
			vel_new = (vel_q > dv) ? vel_q - dv : '0;
		else if (vsum > {1'b0, speed_q})
			vel_new = speed_q;
		else
			vel_new = vsum[DATA_W-1:0];
	end

	assign psum    = {1'b0, pos_q} + {1'b0, dp};
	assign pos_new = (psum > {1'b0, tgt_q}) ? tgt_q : psum[DATA_W-1:0];

	assign sp_raw = prod_q[SP_W+FRAC_W:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q   <= TARGET_RST;
			accel_q <= ACCEL_RST;
			speed_q <= SPEED_RST;
			cpf_q   <= CPF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET: tgt_q   <= cfg_data;
				REG_ACCEL:  accel_q <= cfg_data;
				REG_SPEED:  speed_q <= cfg_data;
				REG_CPF:    cpf_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			vel_q    <= '0;
			moving_q <= 1'b0;
		end else if (ctrl.start) begin
			pos_q    <= '0;
			vel_q    <= '0;
			moving_q <= 1'b1;
		end else if (ctrl.stop) begin
			moving_q <= 1'b0;
		end else if (ctrl.upd_v) begin
			vel_q <= vel_new;
		end else if (ctrl.upd_p) begin
			pos_q <= pos_new;
			if (psum >= {1'b0, tgt_q})
				moving_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture)
			dt_q <= s_elapsed;
		if (ctrl.mul_en)
			prod_q <= prod_d;
		if (ctrl.save_vv)
			vv_q <= prod_q;
		if (ctrl.save_brake)
			brake_q <= (vv3 > ar2);
		if (ctrl.load_out) begin
			sp_q   <= sp_raw[SP_W] ? SP_MAX : sp_raw[SP_W-1:0];
			done_q <= (pos_q >= tgt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.load_out)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	assign sts.moving    = moving_q;
	assign sts.at_target = (pos_q >= tgt_q);
	assign sts.out_free  = !out_valid_q || m_tready;

	assign m_tvalid   = out_valid_q;
	assign m_setpoint = sp_q;
	assign m_done     = done_q;

	a_pos_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.upd_p && !cfg_we |=> pos_q <= tgt_q)
		else $error("position passed the target");

	a_stop_at_target: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.upd_p && !cfg_we |=> (!moving_q || pos_q < tgt_q))
		else $error("move still armed at target");

	a_speed_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.upd_v && !brake_q && !cfg_we |=> vel_q <= speed_q)
		else $error("velocity above ceiling after accelerating");

endmodule

// ----- sv/trapezoid_motion_profile_top.sv -----
`timescale 1ns / 1ps
// channel | dir | handshake           | payload
// s_*     | in  | s_tvalid / s_tready | tdata[15:0] elapsed, tuser cmd (1 start, 0 tick)
// m_*     | out | m_tvalid / m_tready | tdata[30:0] setpoint, tdata[31] done_res
// cfg_*   | in  | cfg_valid/cfg_ready | cfg_index register number, cfg_data 24 bit value
//
// a tick on an active move steps through mul_vv, mul_ar, mul_dv, upd_v, mul_dp, upd_p, mul_sp
// and out from input transfer to result load, a start or any other tick through mul_sp and out
// only; the single shared 24x24 multiplier is used five times per moving tick, which is why
// the steps are sequential; s_tready rises as the result sits in the output register, so
// a new item is only taken once the previous result has been loaded
// reset clears position, velocity and the move flag, and loads register defaults
// m_tready low holds the result and the work stops in the last state; cfg is always ready

module trapezoid_motion_profile_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [15:0] elapsed
	input  logic                          s_tuser,   // [0] cmd
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // [30:0] setpoint, [31] done_res
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tmp_pkg::DATA_W-1:0]    cfg_data
);
	import tmp_pkg::*;

	ctrl_t           ctrl;
	sts_t            sts;
	logic [SP_W-1:0] setpoint;
	logic            done_res;

	// the user must keep writes between items, which the block does not enforce; the port never pushes back
	assign cfg_ready = 1'b1;

	tmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_cmd    (s_tuser),
		.sts      (sts),
		.ctrl     (ctrl)
	);

	tmp_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_elapsed  (s_tdata),
		.ctrl       (ctrl),
		.sts        (sts),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_setpoint (setpoint),
		.m_done     (done_res)
	);

	// done flag rides in the top bit of the setpoint word
	assign m_tdata = {done_res, setpoint};

endmodule
